// ===== src/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the Miller-Rabin prime test core.
// ----------------------------------------------------------------------------
package mrpt_pkg;

   localparam int BASE_COUNT = 7;
   localparam int BASE_IDX_W = 3;
   localparam int BASE_W     = 31;

   function automatic logic [BASE_W-1:0] witness_base(input logic [BASE_IDX_W-1:0] idx);
      logic [BASE_W-1:0] b;
      case (idx)
         3'd0:    b = 31'd2;
         3'd1:    b = 31'd325;
         3'd2:    b = 31'd9375;
         3'd3:    b = 31'd28178;
         3'd4:    b = 31'd450775;
         3'd5:    b = 31'd9780504;
         3'd6:    b = 31'd1795265022;
         default: b = 31'd0;
      endcase
      return b;
   endfunction

endpackage

// ===== src/mrpt_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mrpt_mulmod #(
   parameter int W = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] prod
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W:0]   acc_sum;
   logic [W:0]   dbl_sum;

   assign acc_sum = {1'b0, acc_ff} + {1'b0, a_ff};
   assign dbl_sum = {1'b0, a_ff} + {1'b0, a_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = (acc_sum >= {1'b0, m}) ? W'(acc_sum - {1'b0, m}) : W'(acc_sum);
            end
            a_in = (dbl_sum >= {1'b0, m}) ? W'(dbl_sum - {1'b0, m}) : W'(dbl_sum);
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== src/mrpt_seq.sv =====
// ----------------------------------------------------------------------------
// mrpt_seq
// Test sequencer: screens, splits n-1, runs bases through the shared multiplier.
// ----------------------------------------------------------------------------
module mrpt_seq
   import mrpt_pkg::*;
#(
   parameter int W = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] n,
   output logic         idle,
   output logic         fin,
   output logic         verdict
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCRN  = 4'd1;
   localparam logic [3:0] S_SPLIT = 4'd2;
   localparam logic [3:0] S_BASE  = 4'd3;
   localparam logic [3:0] S_PSTEP = 4'd4;
   localparam logic [3:0] S_PMUL  = 4'd5;
   localparam logic [3:0] S_PSQ   = 4'd6;
   localparam logic [3:0] S_CHK   = 4'd7;
   localparam logic [3:0] S_SQ    = 4'd8;
   localparam logic [3:0] S_SQW   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam int SW = $clog2(W + 1);

   logic [3:0]          st_ff, st_in;
   logic [W-1:0]        n_ff, n_in;
   logic [W-1:0]        d_ff, d_in;
   logic [W-1:0]        e_ff, e_in;
   logic [W-1:0]        x_ff, x_in;
   logic [W-1:0]        b_ff, b_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [SW-1:0]       t_ff, t_in;
   logic [BASE_IDX_W-1:0] bi_ff, bi_in;
   logic                res_ff, res_in;

   logic                mm_start;
   logic [W-1:0]        mm_a, mm_b;
   logic                mm_done;
   logic [W-1:0]        mm_prod;
   logic [W-1:0]        nm1;
   logic [63:0]         base_ext;
   logic [63:0]         n_ext;

   assign nm1      = n_ff - W'(1);
   assign base_ext = 64'(witness_base(bi_ff));
   assign n_ext    = 64'(n_ff);

   mrpt_mulmod #(.W(W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mm_start),
      .a     (mm_a),
      .b     (mm_b),
      .m     (n_ff),
      .done  (mm_done),
      .prod  (mm_prod)
   );

   always_comb begin
      st_in    = st_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      x_in     = x_ff;
      b_in     = b_ff;
      s_in     = s_ff;
      t_in     = t_ff;
      bi_in    = bi_ff;
      res_in   = res_ff;
      mm_start = 1'b0;
      mm_a     = x_ff;
      mm_b     = x_ff;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               n_in  = n;
               st_in = S_SCRN;
            end
         end
         S_SCRN: begin
            st_in = S_DONE;
            if (n_ff <= W'(1)) begin
               res_in = 1'b0;
            end else if (n_ext == 64'd2 || n_ext == 64'd7 || n_ext == 64'd61) begin
               res_in = 1'b1;
            end else if (!n_ff[0]) begin
               res_in = 1'b0;
            end else begin
               d_in  = nm1;
               s_in  = '0;
               bi_in = '0;
               st_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + SW'(1);
            end else begin
               st_in = S_BASE;
            end
         end
         S_BASE: begin
            if (32'(bi_ff) == BASE_COUNT) begin
               res_in = 1'b1;
               st_in  = S_DONE;
            end else if (n_ext <= base_ext) begin
               res_in = 1'b1;
               st_in  = S_DONE;
            end else begin
               x_in  = W'(1);
               b_in  = W'(base_ext);
               e_in  = d_ff;
               st_in = S_PSTEP;
            end
         end
         S_PSTEP: begin
            if (e_ff == '0) begin
               t_in  = '0;
               st_in = S_CHK;
            end else if (e_ff[0]) begin
               mm_start = 1'b1;
               mm_a     = x_ff;
               mm_b     = b_ff;
               st_in    = S_PMUL;
            end else begin
               mm_start = 1'b1;
               mm_a     = b_ff;
               mm_b     = b_ff;
               st_in    = S_PSQ;
            end
         end
         S_PMUL: begin
            if (mm_done) begin
               x_in     = mm_prod;
               mm_start = 1'b1;
               mm_a     = b_ff;
               mm_b     = b_ff;
               st_in    = S_PSQ;
            end
         end
         S_PSQ: begin
            if (mm_done) begin
               b_in  = mm_prod;
               e_in  = e_ff >> 1;
               st_in = S_PSTEP;
            end
         end
         S_CHK: begin
            if (t_ff == '0 && x_ff == W'(1)) begin
               bi_in = bi_ff + BASE_IDX_W'(1);
               st_in = S_BASE;
            end else if (t_ff == s_ff) begin
               res_in = 1'b0;
               st_in  = S_DONE;
            end else if (x_ff == nm1) begin
               bi_in = bi_ff + BASE_IDX_W'(1);
               st_in = S_BASE;
            end else begin
               st_in = S_SQ;
            end
         end
         S_SQ: begin
            mm_start = 1'b1;
            st_in    = S_SQW;
         end
         S_SQW: begin
            if (mm_done) begin
               x_in  = mm_prod;
               t_in  = t_ff + SW'(1);
               st_in = S_CHK;
            end
         end
         S_DONE: begin
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
      n_ff   <= n_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      x_ff   <= x_in;
      b_ff   <= b_in;
      s_ff   <= s_in;
      t_ff   <= t_in;
      bi_ff  <= bi_in;
      res_ff <= res_in;
   end

   assign idle    = (st_ff == S_IDLE);
   assign fin     = (st_ff == S_DONE);
   assign verdict = res_ff;

endmodule

// ===== src/miller_rabin_prime_test_64_core.sv =====
// Trivial values are settled by the screening step; large odd candidates run up to
//   two bit-serial modular multiplies per exponent bit, one at a time, for each of
//   up to seven bases.
// Throughput: one candidate at a time; req_tready is low from accept until the
//   result has been taken.
// Reset: synchronous active-high reset returns the core to idle, no result held.
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_core
// Deterministic Miller-Rabin primality test for values up to 63 bits.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_core
   import mrpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] candidate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] is_prime
);

   logic busy_ff, busy_in;
   logic ov_ff, ov_in;
   logic res_ff, res_in;
   logic seq_idle, seq_fin, seq_verdict;
   logic go;

   assign req_tready = !busy_ff && seq_idle;
   assign go         = req_tvalid && req_tready;

   mrpt_seq #(.W(VALUE_WIDTH)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (go),
      .n       (req_tdata[VALUE_WIDTH-1:0]),
      .idle    (seq_idle),
      .fin     (seq_fin),
      .verdict (seq_verdict)
   );

   always_comb begin
      busy_in = busy_ff;
      ov_in   = ov_ff;
      res_in  = res_ff;
      if (go) busy_in = 1'b1;
      if (seq_fin) begin
         ov_in  = 1'b1;
         res_in = seq_verdict;
      end
      if (ov_ff && rsp_tready) begin
         ov_in   = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {7'd0, res_ff};

endmodule

// ===== src/mrpt_checker.sv =====
// ----------------------------------------------------------------------------
// mrpt_checker
// Port-level checks for the prime test core, bound to the top level.
// ----------------------------------------------------------------------------
module mrpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0) else $error("pad bits set");

endmodule

bind miller_rabin_prime_test_64_core mrpt_checker u_mrpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/mrpt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrpt_scoreboard
// Watches both streams of the prime test core, computes the expected verdict
// for every candidate transfer and compares it with each result transfer.
// ----------------------------------------------------------------------------
module mrpt_scoreboard #(
   parameter int VALUE_WIDTH = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] candidate
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] is_prime
   output int          fail_count,
   output int          pending
);

   logic verdict_q[$];

   function automatic logic [63:0] addm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] r;
      r = a + b;
      return (r >= m) ? r - m : r;
   endfunction

   function automatic logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      while (b != 0) begin
         if (b[0]) acc = addm(acc, a, m);
         a = addm(a, a, m);
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] powm(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      r = 1 % m;
      while (e != 0) begin
         if (e[0]) r = mulm(r, b, m);
         b = mulm(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic primality(logic [63:0] raw);
      logic [63:0] n, d, x, a;
      logic [63:0] bases[7];
      int s, t;
      bases = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                64'd1795265022};
      n = raw & ((64'd1 << VALUE_WIDTH) - 1);
      if (n <= 1) return 1'b0;
      if (n == 2 || n == 7 || n == 61) return 1'b1;
      if (!n[0]) return 1'b0;
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < 7; i++) begin
         a = bases[i];
         if (n <= a) return 1'b1;
         x = powm(a, d, n);
         if (x != 1) begin
            for (t = 0; t < s; t++) begin
               if (x == n - 1) break;
               x = mulm(x, x, n);
            end
            if (t == s) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   assign pending = verdict_q.size();

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) verdict_q.push_back(primality(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result transfer, is_prime=%0b", rsp_tdata[0]);
               fail_count <= fail_count + 1;
            end else if (rsp_tdata !== {7'd0, verdict_q[0]}) begin
               $error("is_prime: expected %0b, actual %0b (tdata %h)",
                      verdict_q[0], rsp_tdata[0], rsp_tdata);
               fail_count <= fail_count + 1;
               void'(verdict_q.pop_front());
            end else begin
               void'(verdict_q.pop_front());
            end
         end
      end
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds candidates to the prime test core through four idle/stall phases,
// directed edge values first, then mostly small random values, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   int          fail_count;
   int          pending;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet = 0;

   localparam int WATCHDOG = 600000;

   always #2 clock = ~clock;

   miller_rabin_prime_test_64_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   mrpt_scoreboard u_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
         $display("[miller_rabin_prime_test_64_core] ERROR");
         $finish;
      end
   end

   task automatic send_candidate(input logic [63:0] v);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [63:0] random_candidate();
      logic [63:0] v;
      int r;
      r = $urandom_range(99);
      if (r < 50)      v = 64'($urandom_range(20000));
      else if (r < 72) v = 64'($urandom_range(1 << 20) | 1);
      else if (r < 88) v = {$urandom, $urandom};
      else             v = 64'($urandom_range(65535) | 1) * 64'($urandom_range(65535) | 1);
      v[63] = 1'($urandom_range(1));
      return v;
   endfunction

   logic [63:0] directed[] = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd7, 64'd61, 64'd62, 64'd9, 64'd325,
      64'd341, 64'd2047, 64'd65537, 64'd3215031751, 64'd3825123056546413051,
      64'h1FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFE7, 64'h7FFF_FFFF_FFFF_FFFF,
      64'h7FFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0002, 64'h8000_0000_0000_0007,
      64'hFFFF_FFFF_FFFF_FFFF, 64'd1795265022, 64'd1795265023
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_candidate(directed[i]);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         for (int k = 0; k < 25; k++) begin
            if (ph == 1 && k == 12) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            send_candidate(random_candidate());
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("[miller_rabin_prime_test_64_core] OK");
      else $display("[miller_rabin_prime_test_64_core] ERROR");
      $finish;
   end

endmodule
